// File: hw/rtl/mkss_pkg.sv
// ----------------------------------------------------------------------------
// mkss_pkg
// Shared types, codes and helpers of the multiplexed key and switch scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mkss_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SELECT = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_SWITCH = 2'd2,
    KIND_SYNC   = 2'd3
  } kind_t;

  localparam int unsigned NUM_LINES  = 8;
  localparam int unsigned NUM_PHASES = 4;
  localparam logic [1:0]  LAST_PHASE = 2'd3;

  // Work left for one input item, handed from the scan stage to the emitter
  typedef struct packed {
    logic [7:0] vec;      // completed scan vector
    logic [7:0] btn_rem;  // button lines still to report
    logic       btn_sync; // sync after the button group pending
    logic [7:0] sw_rem;   // switch lines still to report
    logic       sw_sync;  // sync after the switch group pending
    logic [1:0] sel;      // next phase for the select update
  } job_t;

  // Index of the lowest set bit (0 when none is set)
  function automatic logic [2:0] lowest_bit(input logic [7:0] bits);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (bits[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mkss_scan.sv
// ----------------------------------------------------------------------------
// mkss_scan
// Scan state: phase, vector assembly, previous vector and the change check.
// Builds the job for each accepted sample.
// ----------------------------------------------------------------------------
`default_nettype none

module mkss_scan
  import mkss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       accept,
  input  wire logic       mux_out_one,
  input  wire logic       mux_out_two,
  output job_t            job
);

  logic [7:0] switch_mask;
  logic [1:0] scan_phase;
  logic [7:0] assembled_bits;
  logic [7:0] previous_vector;
  logic       primed;

  logic [7:0] assembled_next;
  logic [7:0] changed;
  logic       scan_done;
  logic       btn_rep;
  logic       sw_rep;

  // Insert the sample at the current phase and check for changes
  always_comb begin
    assembled_next = assembled_bits;
    assembled_next[{scan_phase, 1'b0} +: 2] = {mux_out_one, mux_out_two};
    scan_done = (scan_phase == LAST_PHASE);
    changed   = previous_vector ^ assembled_next;
    if (!primed) begin
      btn_rep = 1'b0;
      sw_rep  = |switch_mask;
    end else begin
      btn_rep = |(changed & ~switch_mask);
      sw_rep  = |(changed & switch_mask);
    end
    job.vec      = assembled_next;
    job.btn_rem  = (scan_done && btn_rep) ? ~switch_mask : 8'h00;
    job.btn_sync = scan_done && btn_rep;
    job.sw_rem   = (scan_done && sw_rep) ? switch_mask : 8'h00;
    job.sw_sync  = scan_done && sw_rep;
    job.sel      = scan_phase + 2'd1;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_mask <= 8'h00;
    end else if (cfg_we) begin
      switch_mask <= cfg_wdata;
    end
  end

  // Scan state advances on every accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase      <= 2'd0;
      assembled_bits  <= 8'h00;
      previous_vector <= 8'h00;
      primed          <= 1'b0;
    end else if (accept) begin
      scan_phase <= scan_phase + 2'd1;
      if (scan_done) begin
        assembled_bits  <= 8'h00;
        previous_vector <= assembled_next;
        primed          <= 1'b1;
      end else begin
        assembled_bits <= assembled_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mkss_emit.sv
// ----------------------------------------------------------------------------
// mkss_emit
// Job register and result serializer: one result per cycle into the output
// register while m_tready does not stall it, events first, select update last.
// ----------------------------------------------------------------------------
`default_nettype none

module mkss_emit
  import mkss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire job_t       job_in,
  input  wire logic       accept,
  output logic            ready,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [2:0] event_code, [3] event_value,
                                     // [4] select_a, [5] select_b, [7:6] zero
  output logic [1:0]      m_tuser,   // [1:0] event_kind
  output logic            m_tlast
);

  job_t       job;
  job_t       job_next;
  logic       job_valid;
  logic [2:0] sw_idx;
  logic [2:0] sw_idx_next;
  logic [2:0] bit_idx;
  logic       load_out;
  logic       step;
  logic       job_done;

  kind_t      step_kind;
  logic [2:0] step_code;
  logic       step_value;
  logic [1:0] step_sel;
  logic       step_last;

  // Pick the next result of the current job
  always_comb begin
    job_next    = job;
    sw_idx_next = sw_idx;
    step_kind   = KIND_SELECT;
    step_code   = 3'd0;
    step_value  = 1'b0;
    step_sel    = 2'd0;
    step_last   = 1'b0;
    bit_idx     = 3'd0;
    if (|job.btn_rem) begin
      bit_idx          = lowest_bit(job.btn_rem);
      step_kind        = KIND_KEY;
      step_code        = bit_idx;
      step_value       = job.vec[bit_idx];
      job_next.btn_rem = job.btn_rem & (job.btn_rem - 8'd1);
    end else if (job.btn_sync) begin
      step_kind         = KIND_SYNC;
      job_next.btn_sync = 1'b0;
    end else if (|job.sw_rem) begin
      bit_idx         = lowest_bit(job.sw_rem);
      step_kind       = KIND_SWITCH;
      step_code       = sw_idx;
      step_value      = ~job.vec[bit_idx];
      job_next.sw_rem = job.sw_rem & (job.sw_rem - 8'd1);
      sw_idx_next     = sw_idx + 3'd1;
    end else if (job.sw_sync) begin
      step_kind        = KIND_SYNC;
      job_next.sw_sync = 1'b0;
    end else begin
      step_kind = KIND_SELECT;
      step_sel  = job.sel;
      step_last = 1'b1;
    end
  end

  // Handshake control
  assign load_out = !m_tvalid || m_tready;
  assign step     = job_valid && load_out;
  assign job_done = step && step_last;
  assign ready    = !job_valid || job_done;

  // Job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job    <= job_in;
      sw_idx <= 3'd0;
    end else if (step) begin
      job    <= job_next;
      sw_idx <= sw_idx_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {2'b00, step_sel[1], step_sel[0], step_value, step_code};
      m_tuser <= step_kind;
      m_tlast <= step_last;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mux_key_switch_scanner_unit.sv
// ----------------------------------------------------------------------------
// mux_key_switch_scanner_unit
// Scanner for eight button and switch lines read through a dual 4-to-1 mux.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one settled sample of both mux outputs per transaction
//   (s_tdata[0] output 1, s_tdata[1] output 2) at the current select phase.
//   m_* returns the results of that sample: key, switch and sync events,
//   then a select update (m_tlast = 1) with the select lines for the next
//   phase. cfg_we/cfg_wdata write the switch mask; write only when idle.
//   Path: the first result of a sample passes the job register and then the
//   output register. Throughput: a sample has 1 to 11 results; the
//   serializer issues one result per cycle, unless m_tready stalls it, into a
//   single output register. A new sample is taken in the cycle its
//   predecessor's select update is issued, so plain phases run at one per
//   cycle while the output is not stalled.
//   Reset clears the phase, vector, previous vector, priming and mask; the
//   select lines are assumed to drive phase 0. When m_tready is low the
//   output register holds and s_tready drops once the job stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module mux_key_switch_scanner_unit
  import mkss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [0] mux_out_one, [1] mux_out_two, [7:2] zero
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [2:0] event_code, [3] event_value,
                                     // [4] select_a, [5] select_b, [7:6] zero
  output logic [1:0]      m_tuser,   // [1:0] event_kind
  output logic            m_tlast
);

  job_t job;
  logic accept;

  assign accept = s_tvalid && s_tready;

  // Scan state and change detection
  mkss_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .mux_out_one (s_tdata[0]),
    .mux_out_two (s_tdata[1]),
    .job         (job)
  );

  // Result serializer
  mkss_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .job_in   (job),
    .accept   (accept),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  // The final result of a sample is always the select update
  a_last_is_select: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_SELECT)))
    else $error("tlast does not match select update");

  // Select lines are driven only on a select update
  a_sel_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != KIND_SELECT)) |-> (m_tdata[5:4] == 2'b00))
    else $error("select lines set on an event");

  // Out of reset the block is ready for a sample
  a_ready_after_reset: assert property (@(posedge clk)
    rst ##1 !rst |-> s_tready)
    else $error("not ready after reset");
`endif

endmodule

`default_nettype wire
